// File: rtl/indexed_max_priority_queue_core_macros.svh
// Assertion helpers shared by the checker.
`ifndef INDEXED_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH
`define INDEXED_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define IMPQ_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("impq check failed");

// Next-cycle implication.
`define IMPQ_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("impq check failed");

`endif

// File: rtl/impq_pkg.sv
`default_nettype none
package impq_pkg;

  localparam int unsigned IdW   = 17;
  localparam int unsigned PrioW = 30;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_EDIT   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_EXEC   = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [IdW-1:0]   user_id;
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic           found;
    logic [IdW-1:0] owner;
    logic           overflow;
  } rsp_t;

  typedef struct packed {
    logic             vld;
    logic [PrioW-1:0] prio;
    logic [IdW-1:0]   tid;
    logic [IdW-1:0]   own;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic clear_en;
    logic start;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_full;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/impq_ctrl.sv
`default_nettype none
module impq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire impq_pkg::status_t status_i,
  output impq_pkg::cmd_t        cmd_o
);
  import impq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (!status_i.out_full) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/impq_dp.sv
`default_nettype none
module impq_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire impq_pkg::req_t   in_data_i,
  input  wire impq_pkg::cmd_t   cmd_i,
  output impq_pkg::status_t     status_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output impq_pkg::rsp_t        out_data_o
);
  import impq_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  slot_t mem [CAPACITY];

  req_t            req_q;
  logic [IdxW-1:0] cnt_q;
  slot_t           rd_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_vld_q;

  logic            match_q, free_q, best_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q, best_idx_q;
  logic [IdW-1:0]  match_own_q, best_own_q, best_tid_q;
  logic [PrioW-1:0] best_prio_q;

  logic            out_valid_q;
  rsp_t            out_q;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  slot_t           wr_word;
  rsp_t            rsp;
  logic            hit, better;

  assign status_o.cnt_last = (cnt_q == LastIdx);
  assign status_o.out_full = out_valid_q && out_stall_i;

  assign hit    = rd_vld_q && rd_q.vld;
  assign better = !best_q || (rd_q.prio > best_prio_q) ||
                  ((rd_q.prio == best_prio_q) && (rd_q.tid > best_tid_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = match_idx_q;
    wr_word = '{vld: 1'b1, prio: req_q.priority_req, tid: req_q.task_id,
                own: req_q.user_id};
    rsp     = '0;
    unique case (func_e'(req_q.func))
      FUNC_ADD: begin
        if (match_q) begin
          wr_en = 1'b1;
        end else if (free_q) begin
          wr_en   = 1'b1;
          wr_addr = free_idx_q;
        end else begin
          rsp.overflow = 1'b1;
        end
      end
      FUNC_EDIT: begin
        wr_en       = match_q;
        wr_word.own = match_own_q;
      end
      FUNC_REMOVE: begin
        wr_en       = match_q;
        wr_word.vld = 1'b0;
      end
      FUNC_EXEC: begin
        wr_en       = best_q;
        wr_addr     = best_idx_q;
        wr_word.vld = 1'b0;
        rsp.found   = best_q;
        rsp.owner   = best_q ? best_own_q : '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      mem[cnt_q] <= '0;
    end else if (cmd_i.commit && wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (cmd_i.scan_en) begin
      rd_q     <= mem[cnt_q];
      rd_idx_q <= cnt_q;
    end
    if (cmd_i.start) begin
      req_q <= in_data_i;
    end
    if (hit && (rd_q.tid == req_q.task_id) && !match_q) begin
      match_idx_q <= rd_idx_q;
      match_own_q <= rd_q.own;
    end
    if (rd_vld_q && !rd_q.vld && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (hit && better) begin
      best_idx_q  <= rd_idx_q;
      best_prio_q <= rd_q.prio;
      best_tid_q  <= rd_q.tid;
      best_own_q  <= rd_q.own;
    end
    if (cmd_i.commit) begin
      out_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_en;
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.clear_en || cmd_i.scan_en) begin
        cnt_q <= status_o.cnt_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.start) begin
        match_q <= 1'b0;
        free_q  <= 1'b0;
        best_q  <= 1'b0;
      end else begin
        if (hit && (rd_q.tid == req_q.task_id)) match_q <= 1'b1;
        if (rd_vld_q && !rd_q.vld) free_q <= 1'b1;
        if (hit) best_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/indexed_max_priority_queue_core.sv
// Channel | Signals                         | Transfer when
// in      | in_valid_i, in_stall_o, in_data_i | in_valid_i && !in_stall_o
// out     | out_valid_o, out_stall_i, out_data_o | out_valid_o && !out_stall_i
//
// Each item takes a scan of the slot memory (ST_SCAN), one read per cycle,
// then ST_LAST and a write-back in ST_WRITE. One item is in flight at a time.
// After reset a clearing pass over every slot holds in_stall_o high.
// A stalled result waits in the output register; the next item may be taken
// meanwhile and holds at write-back until that register frees.
`default_nettype none
module indexed_max_priority_queue_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire impq_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output impq_pkg::rsp_t      out_data_o
);
  import impq_pkg::*;

  cmd_t    cmd;
  status_t status;

  impq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  impq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: rtl/impq_checker.sv
`default_nettype none
`include "indexed_max_priority_queue_core_macros.svh"
module impq_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire impq_pkg::rsp_t out_data_o
);
  `IMPQ_ASSERT_IMP(a_found_no_ovf, clk_i, rst_ni, out_valid_o && out_data_o.found,
    !out_data_o.overflow)
  `IMPQ_ASSERT_IMP(a_owner_zero, clk_i, rst_ni, out_valid_o && !out_data_o.found,
    out_data_o.owner == '0)
  `IMPQ_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))
  `IMPQ_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o)
endmodule

bind indexed_max_priority_queue_core impq_checker u_impq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
